// File: hdl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; clocked, with reset disable
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle as its trigger
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// property holds in the cycle after its trigger
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/slisu_pkg.sv
// types and constants for the sorted list insert/search unit
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package slisu_pkg;

	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef logic signed [VALUE_WIDTH-1:0] key_t;
	typedef logic [CNT_W-1:0] count_t;

	typedef struct packed {
		logic              operation;
		logic signed [31:0] value;
	} cmd_item_t;

	typedef struct packed {
		logic              found;
		logic              overflow;
		logic [6:0]        entry_count;
		logic              list_empty;
		logic signed [31:0] median_value;
	} res_item_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic ins_en;
		logic med_shift;
		key_t key;
	} bcast_t;

	// handed from a cell to its right neighbor
	typedef struct packed {
		key_t entry;
		logic gt;
		logic med;
	} link_t;

	// sign-extend or wrap the 32-bit input to the stored width
	function automatic key_t to_key(logic signed [31:0] v);
		logic signed [63:0] w;
		w = 64'(v);
		return w[VALUE_WIDTH-1:0];
	endfunction

	// stored entry back to the 32-bit result field
	function automatic logic signed [31:0] from_key(key_t k);
		logic signed [63:0] w;
		w = 64'(k);
		return w[31:0];
	endfunction

endpackage

// File: hdl/sorted_list_insert_search_unit.sv
// top level of the sorted list insert/search unit: cell row, count, result pipeline
// depends on slisu_pkg, slisu_cell, slisu_out
`timescale 1ns / 1ps

// Keeps up to CAPACITY signed values in ascending order in a row of cells,
// one entry per cell. An insert item places its value at its sorted spot:
// every cell compares its entry with the key at once, the cells above the
// key take their left neighbor's entry, and the first of them (or the first
// free cell) takes the key. Equal values are kept more than once.
// A lookup item reports whether any stored entry equals the value. Every
// item gives one result with the found and overflow flags, the count after
// the item, an empty flag and the lower median (zero on an empty list).
// An insert into a full list is dropped and flagged as overflow. The block
// takes one item per cycle while results are not stalled; a result passes
// through the hit stage, loaded at the accepting edge, and then the output
// register. A stalled result holds the input back once the hit stage behind
// it is full. The median is tracked by a marker bit per cell that shifts
// right on every second insert, so no search is needed. After reset the
// list is empty and items are taken at once; no clearing pass is needed.

module sorted_list_insert_search_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  slisu_pkg::cmd_item_t  cmd,
	output logic                  res_valid,
	input  logic                  res_stall,
	output slisu_pkg::res_item_t  res
);
	import slisu_pkg::*;

	// number of stored entries
	count_t count_q;

	logic   cmd_accept;
	logic   full;
	logic   do_ins;
	bcast_t bc;

	// per-cell signals of the row
	link_t               rgt   [CAPACITY];
	link_t               lft   [CAPACITY];
	logic [CAPACITY-1:0] occ;
	logic [CAPACITY-1:0] at_end;
	logic [CAPACITY-1:0] hit;
	key_t [CAPACITY-1:0] med_sel;

	assign cmd_accept = cmd_valid && !cmd_stall;
	assign full       = (count_q == CNT_W'(CAPACITY));
	assign do_ins     = cmd_accept && (cmd.operation == OP_INSERT) && !full;

	// the median index moves up when the count goes from an even,
	// nonzero value to the next odd one
	assign bc.ins_en    = do_ins;
	assign bc.med_shift = do_ins && !count_q[0] && (count_q != '0);
	assign bc.key       = to_key(cmd.value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_ins) begin
			count_q <= count_q + 1'b1;
		end
	end

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			// occupancy follows from the count, no per-entry valid bits
			assign occ[i]    = (count_q > CNT_W'(i));
			assign at_end[i] = (count_q == CNT_W'(i));

			if (i == 0) begin : g_head
				// left edge: nothing to shift in, median marker always set
				assign lft[i] = '{entry: '0, gt: 1'b0, med: 1'b1};
			end else begin : g_body
				assign lft[i] = rgt[i-1];
			end

			slisu_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.bc      (bc),
				.left    (lft[i]),
				.occ     (occ[i]),
				.at_end  (at_end[i]),
				.right   (rgt[i]),
				.hit     (hit[i]),
				.med_sel (med_sel[i])
			);
		end
	endgenerate

	// results: hit bits are taken before the update, count and median after
	slisu_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_op    (cmd.operation),
		.cmd_ovf   ((cmd.operation == OP_INSERT) && full),
		.hit       (hit),
		.count     (count_q),
		.med_sel   (med_sel),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// File: hdl/slisu_cell.sv
// one cell of the sorted row: holds one entry and a median marker bit
// depends on slisu_pkg
`timescale 1ns / 1ps

module slisu_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  slisu_pkg::bcast_t bc,
	input  slisu_pkg::link_t  left,
	input  logic              occ,
	input  logic              at_end,
	output slisu_pkg::link_t  right,
	output logic              hit,
	output slisu_pkg::key_t   med_sel
);
	import slisu_pkg::*;

	key_t entry_q;
	logic mark_q;   // median lies right of this cell
	logic gt;

	assign gt    = occ && (entry_q > bc.key);
	assign hit   = occ && (entry_q == bc.key);
	assign right = '{entry: entry_q, gt: gt, med: mark_q};

	// median is here when the left marker is set and ours is clear
	assign med_sel = (occ && left.med && !mark_q) ? entry_q : '0;

	always_ff @(posedge clk) begin
		if (bc.ins_en) begin
			if (left.gt) begin
				entry_q <= left.entry;
			end else if (gt || at_end) begin
				entry_q <= bc.key;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= 1'b0;
		end else if (bc.med_shift) begin
			mark_q <= left.med;
		end
	end

endmodule

// File: hdl/slisu_out.sv
// result pipeline: lookup hit stage and the output register
// depends on slisu_pkg; takes the hit bits before the item updates the cell row, count and median after
`timescale 1ns / 1ps

module slisu_out (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cmd_valid,
	output logic                                   cmd_stall,
	input  logic                                   cmd_op,
	input  logic                                   cmd_ovf,
	input  logic [slisu_pkg::CAPACITY-1:0]         hit,
	input  slisu_pkg::count_t                      count,
	input  slisu_pkg::key_t [slisu_pkg::CAPACITY-1:0] med_sel,
	output logic                                   res_valid,
	input  logic                                   res_stall,
	output slisu_pkg::res_item_t                   res
);
	import slisu_pkg::*;

	logic                s1_valid_q;
	logic                s1_op_q;
	logic                s1_ovf_q;
	logic [CAPACITY-1:0] s1_hit_q;
	logic                res_valid_q;
	res_item_t           res_q;

	logic      res_ready;
	logic      s1_ready;
	logic      s1_move;
	key_t      med_any;
	logic [63:0] cnt_ext;
	res_item_t res_nxt;

	assign res_ready = !res_valid_q || !res_stall;
	assign s1_ready  = !s1_valid_q || res_ready;
	assign s1_move   = s1_valid_q && res_ready;
	assign cmd_stall = !s1_ready;

	// one-hot select: at most one cell drives a nonzero median
	always_comb begin
		med_any = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			med_any = med_any | med_sel[i];
		end
	end

	always_comb begin
		cnt_ext              = 64'(count);
		res_nxt.found        = (s1_op_q == OP_LOOKUP) && (|s1_hit_q);
		res_nxt.overflow     = s1_ovf_q;
		res_nxt.entry_count  = cnt_ext[6:0];
		res_nxt.list_empty   = (count == '0);
		res_nxt.median_value = from_key(med_any);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				s1_valid_q <= cmd_valid;
			end
			if (res_ready) begin
				res_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && s1_ready) begin
			s1_op_q  <= cmd_op;
			s1_ovf_q <= cmd_ovf;
			s1_hit_q <= hit;
		end
		if (s1_move) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: hdl/slisu_checker.sv
// port-level checks for the sorted list insert/search unit, bound to the top
// depends on slisu_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slisu_props (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cmd_valid,
	input logic                 cmd_stall,
	input slisu_pkg::cmd_item_t cmd,
	input logic                 res_valid,
	input logic                 res_stall,
	input slisu_pkg::res_item_t res
);
	import slisu_pkg::*;

	localparam logic [63:0] CAP_EXT = 64'(CAPACITY);
	localparam logic [6:0]  CAP7    = CAP_EXT[6:0];

	// a stalled result stays put
	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res), "result changed while stalled")

	// a result is either a lookup or an insert, never both flags
	`ASSERT_IMPL(a_flags_excl, clk, arst_n, res_valid, !(res.found && res.overflow), "found and overflow together")

	// an empty list reports a zero count and a zero median
	`ASSERT_IMPL(a_empty, clk, arst_n, res_valid && res.list_empty, (res.entry_count == 7'd0) && (res.median_value == 32'sd0), "empty list with count or median")

	// a dropped insert only happens on a full list
	`ASSERT_IMPL(a_ovf_full, clk, arst_n, res_valid && res.overflow, res.entry_count == CAP7, "overflow below capacity")

endmodule

bind sorted_list_insert_search_unit slisu_props u_slisu_props (.*);
